// ===== hw/rtl/mts_pkg.sv =====
// shared constants and field layout for the memory test sequencer
`default_nettype none

package mts_pkg;

    localparam int MAX_PAGES_DEF = 1024;

    localparam logic [31:0] LCG_MUL       = 32'd1664525;
    localparam logic [31:0] LCG_ADD       = 32'd1013904223;
    localparam logic [31:0] GOLDEN        = 32'h9e3779b9;
    localparam logic [31:0] PATTERN_RESET = 32'hfeedface;
    localparam logic [10:0] FAIL_MAX      = 11'd2047;

    localparam int S_DATA_W  = 88;
    localparam int M_DATA_W  = 96;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_START = 2'd1,
        OP_GEN   = 2'd2,
        OP_CHECK = 2'd3
    } opcode_t;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SKIPW   = 3'd5;

endpackage

`default_nettype wire

// ===== hw/rtl/mts_rem.sv =====
// iterative remainder unit, one dividend bit per cycle
`default_nettype none

module mts_rem
    import mts_pkg::*;
#(
    parameter int DVR_W = 11
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [31:0]      dividend,
    input  wire logic [DVR_W-1:0] divisor,
    output logic                  done,
    output logic [DVR_W-1:0]      rem
);

    logic             run_reg;
    logic             done_reg;
    logic [4:0]       cnt_reg;
    logic [31:0]      quo_reg;
    logic [DVR_W-1:0] rem_reg;
    logic [DVR_W:0]   trial;
    logic [DVR_W-1:0] rem_next;

    always_comb
    begin
        trial = {rem_reg, quo_reg[31]};
        if (trial >= {1'b0, divisor})
        begin
            rem_next = DVR_W'(trial - {1'b0, divisor});
        end
        else
        begin
            rem_next = DVR_W'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[30:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mts_order_mem.sv =====
// page order table, one write and one registered read port
`default_nettype none

module mts_order_mem
    import mts_pkg::*;
#(
    parameter int DEPTH  = MAX_PAGES_DEF,
    parameter int ADDR_W = 10
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [ADDR_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [ADDR_W-1:0] rdata
);

    logic [ADDR_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/memory_test_sequencer_core.sv =====
// top level: sequencer around the page order table
//
//  channel  dir  width  carries
//  s_*      in   88+2   pass, position, word index, read word; opcode in tuser
//  m_*      out  96     page, byte offset, expected word, flags, error count
//  cfg_*    in   3+32   register writes, no read-back
//
// generate and check run through the position wrap, table read, multiply and result states
// init runs a sweep that writes the identity one entry a cycle
// start in random mode shuffles the table: per swapped entry an LCG step, a remainder
// from the iterative unit, two reads and two writes; otherwise it goes to the result
// after reset the same identity sweep runs with s_tready low
// a stalled result holds in the output register; the next transfer is taken meanwhile
`default_nettype none

module memory_test_sequencer_core
    import mts_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // pass_number, position, word_index, read_word
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    // opcode
    input  wire logic [1:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // page_index, byte_offset, expected_word, write_enabled, mismatch, error_count
    output logic [M_DATA_W-1:0]       m_tdata,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int ADDR_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_POS_A, S_POS_B, S_READ, S_RDWAIT, S_MUL, S_RESULT,
        S_SH_LCG, S_SH_DIV, S_SH_WAIT, S_SH_RD_A, S_SH_RD_B, S_SH_WR_A, S_SH_WR_B
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [31:0] base_reg;
    logic [10:0] count_reg;
    logic [4:0]  shift_reg;
    logic [8:0]  stride_reg;
    logic        random_reg, skipw_reg;

    // item payload
    opcode_t     op_reg, op_next;
    logic [31:0] pass_reg, pass_next;
    logic [9:0]  pos_reg, pos_next;
    logic [13:0] word_reg, word_next;
    logic [31:0] readw_reg, readw_next;
    logic        wen_reg, wen_next;

    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              due_reg, due_next;
    logic [31:0]       lcg_reg, lcg_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [ADDR_W-1:0] a_reg, a_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [9:0]        page_reg, page_next;
    logic [18:0]       ps_reg, ps_next;
    logic [31:0]       pg_reg, pg_next;
    logic [10:0]       fail_reg, fail_next;
    logic              flag_reg, flag_next;

    logic [9:0]  opage_reg, opage_next;
    logic [33:0] ooff_reg, ooff_next;
    logic [31:0] oexp_reg, oexp_next;
    logic        owen_reg, owen_next;
    logic        omis_reg, omis_next;
    logic [10:0] oerr_reg, oerr_next;
    logic        mvalid_reg, mvalid_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_wdata, mem_raddr, mem_rdata;
    logic              div_start, div_done;
    logic [CNT_W-1:0]  div_rem;
    logic [ADDR_W-1:0] wrap_idx;

    logic [CNT_W-1:0]  n_pages;
    logic [4:0]        shift_eff;
    logic [8:0]        stride_eff;
    logic [34:0]       off_full;
    logic [31:0]       exp_word;
    logic              flag_pre, mis;
    logic              slot_free;

    mts_order_mem #(.DEPTH(MAX_PAGES), .ADDR_W(ADDR_W)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mts_rem #(.DVR_W(CNT_W)) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (lcg_reg),
        .divisor  (i_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    // position modulo table depth
    generate
        if (MAX_PAGES >= 1024)
        begin : g_wide
            assign wrap_idx = ADDR_W'(pos_reg);
        end
        else
        begin : g_wrap
            localparam int RECIP = (1 << 20) / MAX_PAGES;
            logic [29:0] prod_reg;
            logic [9:0]  quo;
            logic [10:0] rem0;
            logic [19:0] qm;
            always_ff @(posedge clk)
            begin
                prod_reg <= 30'(pos_reg * 20'(RECIP));
            end
            always_comb
            begin
                quo  = prod_reg[29:20];
                qm   = quo * 10'(MAX_PAGES);
                rem0 = 11'(pos_reg) - 11'(qm);
                if (rem0 >= 11'(MAX_PAGES))
                begin
                    rem0 = rem0 - 11'(MAX_PAGES);
                end
            end
            assign wrap_idx = ADDR_W'(rem0);
        end
    endgenerate

    always_comb
    begin
        if (32'(count_reg) > 32'(MAX_PAGES))
        begin
            n_pages = CNT_W'(MAX_PAGES);
        end
        else
        begin
            n_pages = CNT_W'(count_reg);
        end
        if (shift_reg < 5'd2)
        begin
            shift_eff = 5'd2;
        end
        else if (shift_reg > 5'd16)
        begin
            shift_eff = 5'd16;
        end
        else
        begin
            shift_eff = shift_reg;
        end
        if (stride_reg == 9'd0)
        begin
            stride_eff = 9'd1;
        end
        else if (stride_reg > 9'd256)
        begin
            stride_eff = 9'd256;
        end
        else
        begin
            stride_eff = stride_reg;
        end
        off_full  = (35'(ps_reg) << shift_eff) + 35'({word_reg, 2'b00});
        exp_word  = base_reg ^ pg_reg ^ 32'(word_reg);
        flag_pre  = (word_reg == 14'd0) ? 1'b0 : flag_reg;
        mis       = (readw_reg != exp_word);
        slot_free = !mvalid_reg || m_tready;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        pass_next   = pass_reg;
        pos_next    = pos_reg;
        word_next   = word_reg;
        readw_next  = readw_reg;
        wen_next    = wen_reg;
        clr_next    = clr_reg;
        due_next    = due_reg;
        lcg_next    = lcg_reg;
        i_next      = i_reg;
        a_next      = a_reg;
        idx_next    = idx_reg;
        page_next   = page_reg;
        ps_next     = ps_reg;
        pg_next     = pg_reg;
        fail_next   = fail_reg;
        flag_next   = flag_reg;
        opage_next  = opage_reg;
        ooff_next   = ooff_reg;
        oexp_next   = oexp_reg;
        owen_next   = owen_reg;
        omis_next   = omis_reg;
        oerr_next   = oerr_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mem_we      = 1'b0;
        mem_waddr   = clr_reg;
        mem_wdata   = clr_reg;
        mem_raddr   = idx_reg;
        div_start   = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(MAX_PAGES - 1))
                begin
                    clr_next   = '0;
                    state_next = due_reg ? S_RESULT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = opcode_t'(s_tuser);
                    pass_next  = s_tdata[31:0];
                    pos_next   = s_tdata[41:32];
                    word_next  = s_tdata[55:42];
                    readw_next = s_tdata[87:56];
                    wen_next   = !(skipw_reg && s_tdata[31:0] == 32'd0);
                    unique case (opcode_t'(s_tuser))
                        OP_INIT:
                        begin
                            fail_next  = '0;
                            flag_next  = 1'b0;
                            due_next   = 1'b1;
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        OP_START:
                        begin
                            fail_next  = '0;
                            flag_next  = 1'b0;
                            state_next = S_RESULT;
                            if (random_reg)
                            begin
                                lcg_next = base_reg ^ s_tdata[31:0];
                                i_next   = n_pages;
                                if (n_pages > CNT_W'(1))
                                begin
                                    state_next = S_SH_LCG;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_POS_A;
                        end
                    endcase
                end
            end
            S_POS_A:
            begin
                state_next = S_POS_B;
            end
            S_POS_B:
            begin
                idx_next   = wrap_idx;
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_RDWAIT;
            end
            S_RDWAIT:
            begin
                page_next  = 10'(mem_rdata);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                ps_next    = page_reg * stride_eff;
                pg_next    = 32'(page_reg * GOLDEN);
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    mvalid_next = 1'b1;
                    omis_next   = 1'b0;
                    if (op_reg == OP_GEN || op_reg == OP_CHECK)
                    begin
                        opage_next = page_reg;
                        ooff_next  = off_full[33:0];
                        oexp_next  = exp_word;
                        owen_next  = wen_reg;
                        oerr_next  = fail_reg;
                        if (op_reg == OP_CHECK)
                        begin
                            omis_next = mis;
                            flag_next = flag_pre;
                            if (mis && !flag_pre)
                            begin
                                flag_next = 1'b1;
                                if (fail_reg < FAIL_MAX)
                                begin
                                    fail_next = fail_reg + 11'd1;
                                    oerr_next = fail_reg + 11'd1;
                                end
                            end
                        end
                    end
                    else
                    begin
                        opage_next = '0;
                        ooff_next  = '0;
                        oexp_next  = '0;
                        owen_next  = (op_reg == OP_START) ? wen_reg : 1'b0;
                        oerr_next  = fail_reg;
                    end
                    due_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_SH_LCG:
            begin
                lcg_next   = lcg_reg * LCG_MUL + LCG_ADD;
                state_next = S_SH_DIV;
            end
            S_SH_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_SH_WAIT;
            end
            S_SH_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_SH_RD_A;
                end
            end
            S_SH_RD_A:
            begin
                mem_raddr  = ADDR_W'(i_reg - 1'b1);
                state_next = S_SH_RD_B;
            end
            S_SH_RD_B:
            begin
                a_next     = mem_rdata;
                mem_raddr  = ADDR_W'(div_rem);
                state_next = S_SH_WR_A;
            end
            S_SH_WR_A:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ADDR_W'(i_reg - 1'b1);
                mem_wdata  = mem_rdata;
                state_next = S_SH_WR_B;
            end
            S_SH_WR_B:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ADDR_W'(div_rem);
                mem_wdata  = a_reg;
                i_next     = i_reg - 1'b1;
                state_next = (i_reg - 1'b1 > CNT_W'(1)) ? S_SH_LCG : S_RESULT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            due_reg    <= 1'b0;
            op_reg     <= OP_INIT;
            lcg_reg    <= '0;
            fail_reg   <= '0;
            flag_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
            base_reg   <= PATTERN_RESET;
            count_reg  <= 11'd1;
            shift_reg  <= 5'd12;
            stride_reg <= 9'd1;
            random_reg <= 1'b0;
            skipw_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            due_reg    <= due_next;
            op_reg     <= op_next;
            lcg_reg    <= lcg_next;
            fail_reg   <= fail_next;
            flag_reg   <= flag_next;
            mvalid_reg <= mvalid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PATTERN: base_reg   <= cfg_data;
                    REG_PAGES:   count_reg  <= cfg_data[10:0];
                    REG_SHIFT:   shift_reg  <= cfg_data[4:0];
                    REG_STRIDE:  stride_reg <= cfg_data[8:0];
                    REG_RANDOM:  random_reg <= cfg_data[0];
                    REG_SKIPW:   skipw_reg  <= cfg_data[0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pass_reg  <= pass_next;
        pos_reg   <= pos_next;
        word_reg  <= word_next;
        readw_reg <= readw_next;
        wen_reg   <= wen_next;
        i_reg     <= i_next;
        a_reg     <= a_next;
        idx_reg   <= idx_next;
        page_reg  <= page_next;
        ps_reg    <= ps_next;
        pg_reg    <= pg_next;
        opage_reg <= opage_next;
        ooff_reg  <= ooff_next;
        oexp_reg  <= oexp_next;
        owen_reg  <= owen_next;
        omis_reg  <= omis_next;
        oerr_reg  <= oerr_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {7'd0, oerr_reg, omis_reg, owen_reg, oexp_reg, ooff_reg, opage_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/mts_checker.sv =====
// port-level checks for the memory test sequencer, bound to the top level
`default_nettype none

module mts_checker
    import mts_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one item at a time: busy right after a transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // a mismatch always leaves a nonzero error count
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[77] |-> m_tdata[88:78] != 11'd0)
        else $error("mismatch without error count");

    // padding above the error count stays zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[95:89] == 7'd0)
        else $error("padding bits set");

endmodule

bind memory_test_sequencer_core mts_checker u_mts_checker (.*);

`default_nettype wire
